[design/idlru_pkg.sv]
// Shared constants and codes for the id slot store with LRU cache.
package idlru_pkg;

  localparam int SlotDepthDefault  = 64;
  localparam int CacheDepthDefault = 16;
  localparam int IdLimitDefault    = 65535;
  localparam int HandleWidth       = 32;
  localparam int IdWidth           = 16;

  localparam logic [2:0] OpCreate = 3'd0;
  localparam logic [2:0] OpRead   = 3'd1;
  localparam logic [2:0] OpUpdate = 3'd2;
  localparam logic [2:0] OpDelete = 3'd3;
  localparam logic [2:0] OpExists = 3'd4;

  localparam logic CfgCacheCap = 1'b0;
  localparam logic CfgSlotCap  = 1'b1;

  localparam logic [4:0] CacheCapReset = 5'd16;
  localparam logic [6:0] SlotCapReset  = 7'd64;

endpackage

[design/id_slot_store_with_lru_cache_core.sv]
// Top level of the id slot store with a fully associative LRU cache.
//
// A command beat is taken at a clock edge where start_i is high and busy_o
// is low. busy_o then stays high until the result is ready; the result is
// shown for one cycle with done_o high, and the next command may be given in
// that same cycle. The receiver cannot hold results off.
// Create with a free slot, and read or exists that hit the cache, pass from
// S_LOOK straight to S_DONE. Read, update, delete and exists that look in the
// primary slots sweep the slot memories one entry a cycle, stopping at the
// first match. A cache insert passes through S_PUT, which evicts the least
// recently used entry, one at a time, while the cache is at or over its capacity.
// Configuration writes on cfg_we_i are taken at any edge and are meant to be
// given while the block is idle.
// Reset clears all valid bits, the counters and the LRU order and sets the id
// counter to one; no clearing pass is needed.
module id_slot_store_with_lru_cache_core #(
  parameter int SLOT_DEPTH  = idlru_pkg::SlotDepthDefault,
  parameter int CACHE_DEPTH = idlru_pkg::CacheDepthDefault,
  parameter int ID_LIMIT    = idlru_pkg::IdLimitDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  operation_i,
  input  logic [15:0] item_id_i,
  input  logic [31:0] handle_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  output logic        done_o,
  output logic        status_o,
  output logic [15:0] issued_id_o,
  output logic [31:0] result_handle_o,
  output logic        found_in_cache_o,
  output logic [6:0]  primary_count_o,
  output logic [4:0]  cache_count_o,
  output logic [31:0] hit_count_o,
  output logic [31:0] miss_count_o
);

  localparam int HW  = idlru_pkg::HandleWidth;
  localparam int IW  = idlru_pkg::IdWidth;
  localparam int SAW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int SCW = $clog2(SLOT_DEPTH + 1);
  localparam int CAW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CCW = $clog2(CACHE_DEPTH + 1);

  typedef logic [CACHE_DEPTH-1:0][CAW-1:0] rank_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOOK = 6'b000010,
    S_SCAN = 6'b000100,
    S_FIN  = 6'b001000,
    S_PUT  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  logic [IW-1:0] slot_id_mem [SLOT_DEPTH];
  logic [HW-1:0] slot_hd_mem [SLOT_DEPTH];

  state_e state_q, state_d;
  logic [2:0] op_q, op_d;
  logic [IW-1:0] id_q, id_d, issued_q, issued_d, ctr_q, ctr_d;
  logic [HW-1:0] h_q, h_d, res_h_q, res_h_d, slot_h_q, slot_h_d;
  logic status_q, status_d, inc_q, inc_d, done_q, done_d, found_q, found_d;
  logic [SLOT_DEPTH-1:0] svalid_q, svalid_d;
  logic [CACHE_DEPTH-1:0] cvalid_q, cvalid_d, cdirty_q, cdirty_d;
  logic [CACHE_DEPTH-1:0][IW-1:0] cid_q, cid_d;
  logic [CACHE_DEPTH-1:0][HW-1:0] chd_q, chd_d;
  rank_t rank_q, rank_d;
  logic [SCW-1:0] used_s_q, used_s_d, scan_q, scan_d;
  logic [CCW-1:0] used_c_q, used_c_d;
  logic [31:0] hits_q, hits_d, miss_q, miss_d;
  logic [4:0] ccap_q, ccap_d;
  logic [6:0] scap_q, scap_d;
  logic pend_q, pend_d;
  logic [SAW-1:0] pa_q, pa_d, slot_q, slot_d;
  logic [IW-1:0] rd_id_q;
  logic [HW-1:0] rd_hd_q;

  logic mem_we, rd_en;
  logic [SAW-1:0] mem_wa;
  logic [IW-1:0] mem_wid;
  logic [HW-1:0] mem_wh;
  logic mem_wid_en;

  logic [IW-1:0] key;
  logic c_hit, s_free, c_free, vic_ok;
  logic [CAW-1:0] c_idx, c_free_idx, vic_idx;
  logic [SAW-1:0] s_free_idx;
  logic [15:0] ccap, scap;
  logic [IW:0] ctr_next;

  function automatic rank_t rank_touch(rank_t r, logic [CACHE_DEPTH-1:0] v,
                                       logic [CAW-1:0] e);
    rank_t o;
    o = r;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (v[i] && (r[i] < r[e])) o[i] = r[i] + 1'b1;
    end
    o[e] = '0;
    return o;
  endfunction

  function automatic rank_t rank_remove(rank_t r, logic [CACHE_DEPTH-1:0] v,
                                        logic [CAW-1:0] e);
    rank_t o;
    o = r;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (v[i] && (r[i] > r[e])) o[i] = r[i] - 1'b1;
    end
    o[e] = '0;
    return o;
  endfunction

  always_comb begin
    ccap = {11'd0, ccap_q};
    if (ccap == 16'd0) ccap = 16'd1;
    else if (ccap > 16'(CACHE_DEPTH)) ccap = 16'(CACHE_DEPTH);
    scap = {9'd0, scap_q};
    if (scap == 16'd0) scap = 16'd1;
    else if (scap > 16'(SLOT_DEPTH)) scap = 16'(SLOT_DEPTH);
    key = (op_q == idlru_pkg::OpCreate) ? issued_q : id_q;
    ctr_next = {1'b0, ctr_q} + 1'b1;
    c_hit = 1'b0;
    c_idx = '0;
    c_free = 1'b0;
    c_free_idx = '0;
    vic_ok = 1'b0;
    vic_idx = '0;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (!c_hit && cvalid_q[i] && (cid_q[i] == key)) begin
        c_hit = 1'b1;
        c_idx = CAW'(i);
      end
      if (!c_free && !cvalid_q[i]) begin
        c_free = 1'b1;
        c_free_idx = CAW'(i);
      end
      if (!vic_ok && cvalid_q[i] && (CCW'(rank_q[i]) == used_c_q - 1'b1)) begin
        vic_ok = 1'b1;
        vic_idx = CAW'(i);
      end
    end
    s_free = 1'b0;
    s_free_idx = '0;
    for (int i = 0; i < SLOT_DEPTH; i++) begin
      if (!s_free && (16'(i) < scap) && !svalid_q[i]) begin
        s_free = 1'b1;
        s_free_idx = SAW'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    id_d = id_q;
    issued_d = issued_q;
    ctr_d = ctr_q;
    h_d = h_q;
    res_h_d = res_h_q;
    slot_h_d = slot_h_q;
    status_d = status_q;
    inc_d = inc_q;
    done_d = 1'b0;
    found_d = found_q;
    svalid_d = svalid_q;
    cvalid_d = cvalid_q;
    cdirty_d = cdirty_q;
    cid_d = cid_q;
    chd_d = chd_q;
    rank_d = rank_q;
    used_s_d = used_s_q;
    used_c_d = used_c_q;
    scan_d = scan_q;
    hits_d = hits_q;
    miss_d = miss_q;
    ccap_d = ccap_q;
    scap_d = scap_q;
    pend_d = 1'b0;
    pa_d = pa_q;
    slot_d = slot_q;
    mem_we = 1'b0;
    mem_wid_en = 1'b0;
    mem_wa = s_free_idx;
    mem_wid = issued_q;
    mem_wh = h_q;
    rd_en = 1'b0;

    if (cfg_we_i) begin
      if (cfg_idx_i == idlru_pkg::CfgCacheCap) ccap_d = cfg_data_i[4:0];
      else scap_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d = operation_i;
          id_d = item_id_i;
          h_d = handle_i;
          status_d = 1'b0;
          inc_d = 1'b0;
          res_h_d = '0;
          issued_d = '0;
          if (operation_i == idlru_pkg::OpCreate) begin
            issued_d = ctr_q;
            ctr_d = (ctr_next >= (IW+1)'(ID_LIMIT)) ? IW'(1) : ctr_next[IW-1:0];
          end
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        scan_d = '0;
        case (op_q)
          idlru_pkg::OpCreate: begin
            if (s_free) begin
              mem_we = 1'b1;
              mem_wid_en = 1'b1;
              svalid_d[s_free_idx] = 1'b1;
              used_s_d = used_s_q + 1'b1;
              state_d = S_DONE;
            end else begin
              state_d = S_PUT;
            end
          end
          idlru_pkg::OpRead, idlru_pkg::OpExists: begin
            if (c_hit) begin
              rank_d = rank_touch(rank_q, cvalid_q, c_idx);
              inc_d = 1'b1;
              if (op_q == idlru_pkg::OpRead) begin
                res_h_d = chd_q[c_idx];
                hits_d = hits_q + 1'b1;
              end
              state_d = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end
          idlru_pkg::OpUpdate, idlru_pkg::OpDelete: state_d = S_SCAN;
          default: state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (scan_q < SCW'(SLOT_DEPTH)) begin
          rd_en = 1'b1;
          pend_d = 1'b1;
          pa_d = scan_q[SAW-1:0];
          scan_d = scan_q + 1'b1;
        end
        if (pend_q && svalid_q[pa_q] && (rd_id_q == id_q)) begin
          found_d = 1'b1;
          slot_d = pa_q;
          slot_h_d = rd_hd_q;
          pend_d = 1'b0;
          state_d = S_FIN;
        end else if (scan_q == SCW'(SLOT_DEPTH)) begin
          found_d = 1'b0;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        state_d = S_DONE;
        case (op_q)
          idlru_pkg::OpRead: begin
            miss_d = miss_q + 1'b1;
            if (found_q) begin
              res_h_d = slot_h_q;
              h_d = slot_h_q;
              state_d = S_PUT;
            end else begin
              status_d = 1'b1;
            end
          end
          idlru_pkg::OpUpdate: begin
            if (found_q) begin
              mem_we = 1'b1;
              mem_wa = slot_q;
            end
            if (c_hit) begin
              rank_d = rank_touch(rank_q, cvalid_q, c_idx);
              chd_d[c_idx] = h_q;
              cdirty_d[c_idx] = 1'b1;
              inc_d = 1'b1;
            end else if (!found_q) begin
              status_d = 1'b1;
            end
          end
          idlru_pkg::OpDelete: begin
            if (found_q) begin
              svalid_d[slot_q] = 1'b0;
              if (used_s_q != '0) used_s_d = used_s_q - 1'b1;
            end
            if (c_hit) begin
              rank_d = rank_remove(rank_q, cvalid_q, c_idx);
              cvalid_d[c_idx] = 1'b0;
              cdirty_d[c_idx] = 1'b0;
              if (used_c_q != '0) used_c_d = used_c_q - 1'b1;
              inc_d = 1'b1;
            end
            if (!found_q && !c_hit) status_d = 1'b1;
          end
          default: status_d = !found_q;
        endcase
      end
      S_PUT: begin
        if (c_hit) begin
          rank_d = rank_touch(rank_q, cvalid_q, c_idx);
          chd_d[c_idx] = h_q;
          cdirty_d[c_idx] = 1'b1;
          state_d = S_DONE;
        end else if ((16'(used_c_q) >= ccap) && vic_ok) begin
          // The victim holds the top rank, so no other rank moves.
          cvalid_d[vic_idx] = 1'b0;
          cdirty_d[vic_idx] = 1'b0;
          rank_d[vic_idx] = '0;
          used_c_d = used_c_q - 1'b1;
        end else begin
          state_d = S_DONE;
          if (c_free) begin
            for (int i = 0; i < CACHE_DEPTH; i++) begin
              if (cvalid_q[i]) rank_d[i] = rank_q[i] + 1'b1;
            end
            rank_d[c_free_idx] = '0;
            cid_d[c_free_idx] = key;
            chd_d[c_free_idx] = h_q;
            cvalid_d[c_free_idx] = 1'b1;
            cdirty_d[c_free_idx] = 1'b0;
            used_c_d = used_c_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_hd_mem[mem_wa] <= mem_wh;
      if (mem_wid_en) slot_id_mem[mem_wa] <= mem_wid;
    end
    if (rd_en) begin
      rd_id_q <= slot_id_mem[scan_q[SAW-1:0]];
      rd_hd_q <= slot_hd_mem[scan_q[SAW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ctr_q <= IW'(1);
      done_q <= 1'b0;
      svalid_q <= '0;
      cvalid_q <= '0;
      cdirty_q <= '0;
      rank_q <= '0;
      used_s_q <= '0;
      used_c_q <= '0;
      hits_q <= '0;
      miss_q <= '0;
      ccap_q <= idlru_pkg::CacheCapReset;
      scap_q <= idlru_pkg::SlotCapReset;
      pend_q <= 1'b0;
      scan_q <= '0;
    end else begin
      state_q <= state_d;
      ctr_q <= ctr_d;
      done_q <= done_d;
      svalid_q <= svalid_d;
      cvalid_q <= cvalid_d;
      cdirty_q <= cdirty_d;
      rank_q <= rank_d;
      used_s_q <= used_s_d;
      used_c_q <= used_c_d;
      hits_q <= hits_d;
      miss_q <= miss_d;
      ccap_q <= ccap_d;
      scap_q <= scap_d;
      pend_q <= pend_d;
      scan_q <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    id_q <= id_d;
    issued_q <= issued_d;
    h_q <= h_d;
    res_h_q <= res_h_d;
    slot_h_q <= slot_h_d;
    status_q <= status_d;
    inc_q <= inc_d;
    found_q <= found_d;
    cid_q <= cid_d;
    chd_q <= chd_d;
    pa_q <= pa_d;
    slot_q <= slot_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign status_o = status_q;
  assign issued_id_o = issued_q;
  assign result_handle_o = res_h_q;
  assign found_in_cache_o = inc_q;
  assign primary_count_o = 7'(used_s_q);
  assign cache_count_o = 5'(used_c_q);
  assign hit_count_o = hits_q;
  assign miss_count_o = miss_q;

  a_cache_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cvalid_q) == int'(used_c_q))
    else $error("cache count differs from cache valid bits");

  a_slot_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(svalid_q) == int'(used_s_q))
    else $error("slot count differs from slot valid bits");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result beat without a command in flight");

endmodule

[test/testbench.sv]
// Self-checking testbench for the id slot store with LRU cache: queued commands, live prediction.
module testbench;

  localparam logic [2:0] OpStats  = 3'd5;
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;
  localparam int NSlot = 64;
  localparam int NCache = 16;
  localparam int StallLimit = 5000;
  localparam logic [6:0] CacheSet [6] = '{7'd16, 7'd1, 7'd4, 7'd0, 7'd31, 7'd2};
  localparam logic [6:0] SlotSet [6]  = '{7'd64, 7'd1, 7'd8, 7'd0, 7'd127, 7'd3};

  typedef enum logic [1:0] {KindCmd, KindCfg, KindPause} kind_e;

  typedef struct {
    kind_e       kind;
    logic [2:0]  op;
    logic [15:0] id;
    logic [31:0] handle;
    logic        cidx;
    logic [6:0]  cdata;
  } beat_t;

  typedef struct {
    logic        status;
    logic [15:0] issued;
    logic [31:0] handle;
    logic        in_cache;
    logic [6:0]  pcount;
    logic [4:0]  ccount;
    logic [31:0] hits;
    logic [31:0] misses;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [2:0]  operation_i = '0;
  logic [15:0] item_id_i = '0;
  logic [31:0] handle_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [6:0]  cfg_data_i = '0;
  logic        busy_o, done_o, status_o, found_in_cache_o;
  logic [15:0] issued_id_o;
  logic [31:0] result_handle_o, hit_count_o, miss_count_o;
  logic [6:0]  primary_count_o;
  logic [4:0]  cache_count_o;

  id_slot_store_with_lru_cache_core u_top (.*);

  beat_t   pending_beats[$];
  result_t expected_results[$];
  beat_t   cur_beat;
  int      n_sent = 0;
  int      n_got = 0;
  int      errors = 0;
  int      cycle = 0;
  int      stall = 0;
  logic [15:0] gen_next = 16'd1;

  // Shadow copy of the block state.
  logic [15:0] s_id[NSlot];
  logic [31:0] s_h[NSlot];
  logic        s_v[NSlot];
  logic [15:0] c_id[NCache];
  logic [31:0] c_h[NCache];
  logic        c_v[NCache];
  logic        c_d[NCache];
  int          c_rank[NCache];
  logic [15:0] id_ctr = 16'd1;
  int          used_s = 0;
  int          used_c = 0;
  logic [31:0] hit_ctr = '0;
  logic [31:0] miss_ctr = '0;
  logic [4:0]  cache_cap = idlru_pkg::CacheCapReset;
  logic [6:0]  slot_cap = idlru_pkg::SlotCapReset;

  initial begin
    for (int i = 0; i < NSlot; i++) s_v[i] = 1'b0;
    for (int i = 0; i < NCache; i++) begin
      c_v[i] = 1'b0;
      c_d[i] = 1'b0;
      c_rank[i] = 0;
    end
  end

  function automatic int clamp(int v, int depth);
    if (v < 1) return 1;
    if (v > depth) return depth;
    return v;
  endfunction

  function automatic int slot_lookup(logic [15:0] id);
    for (int i = 0; i < NSlot; i++) if (s_v[i] && s_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int cache_lookup(logic [15:0] id);
    for (int i = 0; i < NCache; i++) if (c_v[i] && c_id[i] == id) return i;
    return -1;
  endfunction

  task automatic cache_refresh(int e);
    int r;
    r = c_rank[e];
    for (int i = 0; i < NCache; i++) if (c_v[i] && c_rank[i] < r) c_rank[i]++;
    c_rank[e] = 0;
  endtask

  task automatic cache_drop(int e);
    int r;
    r = c_rank[e];
    c_v[e] = 1'b0;
    c_d[e] = 1'b0;
    c_rank[e] = 0;
    for (int i = 0; i < NCache; i++) if (c_v[i] && c_rank[i] > r) c_rank[i]--;
    if (used_c > 0) used_c--;
  endtask

  task automatic cache_insert(logic [15:0] id, logic [31:0] h);
    int e, cap, victim, slot;
    e = cache_lookup(id);
    cap = clamp(int'(cache_cap), NCache);
    if (e >= 0) begin
      cache_refresh(e);
      c_h[e] = h;
      c_d[e] = 1'b1;
      return;
    end
    while (used_c >= cap) begin
      victim = -1;
      for (int i = 0; i < NCache; i++)
        if (c_v[i] && (victim < 0 || c_rank[i] > c_rank[victim])) victim = i;
      if (victim < 0) break;
      cache_drop(victim);
    end
    slot = -1;
    for (int i = 0; i < NCache; i++) if (!c_v[i] && slot < 0) slot = i;
    if (slot < 0) return;
    for (int i = 0; i < NCache; i++) if (c_v[i]) c_rank[i]++;
    c_id[slot] = id;
    c_h[slot] = h;
    c_v[slot] = 1'b1;
    c_d[slot] = 1'b0;
    c_rank[slot] = 0;
    used_c++;
  endtask

  task automatic predict(beat_t b, output result_t r);
    int s, c, scap;
    logic [16:0] nxt;
    r = '{default: '0};
    case (b.op)
      idlru_pkg::OpCreate: begin
        scap = clamp(int'(slot_cap), NSlot);
        r.issued = id_ctr;
        nxt = {1'b0, id_ctr} + 17'd1;
        id_ctr = (nxt >= 17'(idlru_pkg::IdLimitDefault)) ? 16'd1 : nxt[15:0];
        s = -1;
        for (int i = 0; i < scap; i++) if (!s_v[i] && s < 0) s = i;
        if (s >= 0) begin
          s_id[s] = r.issued;
          s_h[s] = b.handle;
          s_v[s] = 1'b1;
          used_s++;
        end else begin
          cache_insert(r.issued, b.handle);
        end
      end
      idlru_pkg::OpRead: begin
        c = cache_lookup(b.id);
        if (c >= 0) begin
          cache_refresh(c);
          r.handle = c_h[c];
          hit_ctr++;
          r.in_cache = 1'b1;
        end else begin
          miss_ctr++;
          s = slot_lookup(b.id);
          if (s >= 0) begin
            r.handle = s_h[s];
            cache_insert(b.id, r.handle);
          end else begin
            r.status = 1'b1;
          end
        end
      end
      idlru_pkg::OpUpdate: begin
        s = slot_lookup(b.id);
        if (s >= 0) s_h[s] = b.handle;
        c = cache_lookup(b.id);
        if (c >= 0) begin
          cache_refresh(c);
          c_h[c] = b.handle;
          c_d[c] = 1'b1;
          r.in_cache = 1'b1;
        end else if (s < 0) begin
          r.status = 1'b1;
        end
      end
      idlru_pkg::OpDelete: begin
        s = slot_lookup(b.id);
        if (s >= 0) begin
          s_v[s] = 1'b0;
          if (used_s > 0) used_s--;
        end
        c = cache_lookup(b.id);
        if (c >= 0) begin
          cache_drop(c);
          r.in_cache = 1'b1;
        end
        if (s < 0 && c < 0) r.status = 1'b1;
      end
      idlru_pkg::OpExists: begin
        c = cache_lookup(b.id);
        if (c >= 0) begin
          cache_refresh(c);
          r.in_cache = 1'b1;
        end else if (slot_lookup(b.id) < 0) begin
          r.status = 1'b1;
        end
      end
      default: ;
    endcase
    r.pcount = used_s[6:0];
    r.ccount = used_c[4:0];
    r.hits = hit_ctr;
    r.misses = miss_ctr;
  endtask

  // Stimulus construction.
  task automatic add_cmd(logic [2:0] op, logic [15:0] id, logic [31:0] h);
    beat_t b;
    b = '{kind: KindCmd, op: op, id: id, handle: h, cidx: 1'b0, cdata: '0};
    pending_beats.push_back(b);
    if (op == idlru_pkg::OpCreate)
      gen_next = (int'(gen_next) >= idlru_pkg::IdLimitDefault - 1) ? 16'd1 : gen_next + 16'd1;
  endtask

  task automatic add_cfg(logic idx, logic [6:0] d);
    beat_t b;
    b = '{kind: KindCfg, op: '0, id: '0, handle: '0, cidx: idx, cdata: d};
    pending_beats.push_back(b);
  endtask

  task automatic add_pause();
    beat_t b;
    b = '{kind: KindPause, op: '0, id: '0, handle: '0, cidx: 1'b0, cdata: '0};
    pending_beats.push_back(b);
  endtask

  function automatic logic [15:0] recent_id();
    int k, v;
    k = $urandom_range(100);
    if (k < 82) begin
      v = int'(gen_next) - int'($urandom_range(1, 24));
      if (v < 1) v += idlru_pkg::IdLimitDefault - 1;
      return v[15:0];
    end
    if (k < 88) return ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task automatic add_random_cmd();
    int k;
    logic [31:0] h;
    k = $urandom_range(99);
    h = ($urandom_range(9) == 0) ? (($urandom_range(1)) ? 32'h0 : 32'hFFFF_FFFF) : $urandom;
    if (k < 30) add_cmd(idlru_pkg::OpCreate, 16'($urandom), h);
    else if (k < 58) add_cmd(idlru_pkg::OpRead, recent_id(), h);
    else if (k < 70) add_cmd(idlru_pkg::OpUpdate, recent_id(), h);
    else if (k < 83) add_cmd(idlru_pkg::OpDelete, recent_id(), h);
    else if (k < 94) add_cmd(idlru_pkg::OpExists, recent_id(), h);
    else add_cmd(3'(OpStats + $urandom_range(2)), 16'($urandom), $urandom);
  endtask

  // Driver.
  always @(posedge clk_i) begin
    logic  accepted, nstart, nwe, idle;
    result_t r;
    beat_t   b;
    cycle++;
    nstart = start_i;
    nwe = 1'b0;
    accepted = rst_ni && start_i && !busy_o;
    if (accepted) begin
      predict(cur_beat, r);
      expected_results.push_back(r);
      n_sent++;
      nstart = 1'b0;
    end
    if (rst_ni && !nstart && pending_beats.size() > 0) begin
      b = pending_beats[0];
      idle = (n_got == n_sent) && !busy_o && !accepted && !start_i;
      case (b.kind)
        KindCmd: begin
          if ((cycle % 5000) < 1500 || $urandom_range(99) >= 15) begin
            void'(pending_beats.pop_front());
            cur_beat <= b;
            operation_i <= b.op;
            item_id_i <= b.id;
            handle_i <= b.handle;
            nstart = 1'b1;
          end
        end
        KindCfg: begin
          if (idle) begin
            void'(pending_beats.pop_front());
            nwe = 1'b1;
            cfg_idx_i <= b.cidx;
            cfg_data_i <= b.cdata;
            if (b.cidx == idlru_pkg::CfgCacheCap) cache_cap = b.cdata[4:0];
            else slot_cap = b.cdata;
          end
        end
        default: begin
          if (idle) void'(pending_beats.pop_front());
        end
      endcase
    end
    start_i <= nstart;
    cfg_we_i <= nwe;
  end

  function automatic int field_check(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, e, a);
      return 1;
    end
    return 0;
  endfunction

  // Monitor.
  always @(posedge clk_i) begin
    result_t e;
    int bad;
    if (rst_ni && done_o) begin
      n_got <= n_got + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with no command pending", $time);
        errors++;
      end else begin
        e = expected_results.pop_front();
        bad = field_check("status", 32'(e.status), 32'(status_o))
            + field_check("issued_id", 32'(e.issued), 32'(issued_id_o))
            + field_check("result_handle", e.handle, result_handle_o)
            + field_check("found_in_cache", 32'(e.in_cache), 32'(found_in_cache_o))
            + field_check("primary_count", 32'(e.pcount), 32'(primary_count_o))
            + field_check("cache_count", 32'(e.ccount), 32'(cache_count_o))
            + field_check("hit_count", e.hits, hit_count_o)
            + field_check("miss_count", e.misses, miss_count_o);
        errors += bad;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if (rst_ni && !(start_i && !busy_o) && !done_o) stall++;
    else stall = 0;
    if (stall >= StallLimit) begin
      $display("[id_slot_store_with_lru_cache_core] ERROR");
      $finish;
    end
  end

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With one primary slot, ids 2 and 3 go to the cache.
    add_cfg(idlru_pkg::CfgSlotCap, 7'd1);
    add_cmd(idlru_pkg::OpCreate, 16'd0, 32'h0);
    add_cmd(idlru_pkg::OpCreate, 16'd0, 32'hFFFF_FFFF);
    add_cmd(idlru_pkg::OpCreate, 16'd0, 32'h1234_5678);
    add_cmd(idlru_pkg::OpDelete, 16'd1, 32'd0);
    add_cmd(idlru_pkg::OpCreate, 16'd0, 32'hAAAA_5555);
    add_cmd(idlru_pkg::OpCreate, 16'd0, 32'h5555_AAAA);
    add_cmd(idlru_pkg::OpRead, 16'd2, 32'd0);
    add_pause();

    // Directed part at the reset capacities and at the extremes.
    add_cfg(idlru_pkg::CfgSlotCap, 7'd64);
    add_cfg(idlru_pkg::CfgCacheCap, 7'd16);
    add_cmd(idlru_pkg::OpCreate, 16'd0, 32'h0000_0000);
    add_cmd(idlru_pkg::OpCreate, 16'd0, 32'hFFFF_FFFF);
    add_cmd(idlru_pkg::OpRead, 16'd1, 32'd0);
    add_cmd(idlru_pkg::OpRead, 16'd1, 32'd0);
    add_cmd(idlru_pkg::OpRead, 16'd0, 32'd0);
    add_cmd(idlru_pkg::OpRead, 16'hFFFF, 32'd0);
    add_cmd(idlru_pkg::OpUpdate, 16'd1, 32'hDEAD_BEEF);
    add_cmd(idlru_pkg::OpUpdate, 16'd2, 32'h0);
    add_cmd(idlru_pkg::OpUpdate, 16'hFFFF, 32'h1);
    add_cmd(idlru_pkg::OpExists, 16'd1, 32'd0);
    add_cmd(idlru_pkg::OpExists, 16'd2, 32'd0);
    add_cmd(idlru_pkg::OpExists, 16'd0, 32'd0);
    add_cmd(idlru_pkg::OpDelete, 16'd1, 32'd0);
    add_cmd(idlru_pkg::OpDelete, 16'd2, 32'd0);
    add_cmd(idlru_pkg::OpDelete, 16'd1, 32'd0);
    add_cmd(OpStats, 16'hFFFF, 32'hFFFF_FFFF);
    add_cmd(OpSpare6, 16'hFFFF, 32'hFFFF_FFFF);
    add_cmd(OpSpare7, 16'd0, 32'd0);
    add_pause();
    add_cfg(idlru_pkg::CfgCacheCap, 7'd0);
    add_cfg(idlru_pkg::CfgSlotCap, 7'd0);
    add_cmd(idlru_pkg::OpCreate, 16'd0, $urandom);
    add_cmd(idlru_pkg::OpCreate, 16'd0, $urandom);
    add_cmd(idlru_pkg::OpCreate, 16'd0, $urandom);
    add_cmd(idlru_pkg::OpRead, gen_next - 16'd3, 32'd0);

    // Random phases over a range of capacity settings.
    for (int p = 0; p < 6; p++) begin
      add_pause();
      add_cfg(idlru_pkg::CfgCacheCap, CacheSet[p]);
      add_cfg(idlru_pkg::CfgSlotCap, SlotSet[p]);
      for (int n = 0; n < 75; n++) begin
        add_random_cmd();
        if (n == 40) add_pause();
      end
    end

    wait (pending_beats.size() == 0 && !start_i);
    wait (n_got == n_sent);
    repeat (80) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[id_slot_store_with_lru_cache_core] OK");
    end else begin
      $display("[id_slot_store_with_lru_cache_core] ERROR");
    end
    $finish;
  end

endmodule
